@@ src/ipv6_lpm_pkg.sv @@
// Shared types, codes and helpers for the IPv6 longest-prefix-match table.
// No dependencies; used by every module under src.
package ipv6_lpm_pkg;

    localparam int unsigned DEF_TABLE_ENTRIES = 256;
    localparam int unsigned DEF_ADDRESS_BITS  = 128;
    localparam int unsigned LEN_W             = 8;
    localparam int unsigned VALUE_W           = 32;
    localparam int unsigned COUNT_W           = 9;
    localparam int unsigned IN_DATA_W         = 176;
    localparam int unsigned OUT_DATA_W        = 48;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEN   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NO_SPACE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS1,
        S_PASS2,
        S_DONE
    } state_t;

    // Token walking the chain of cells, one cell per cycle
    typedef struct packed {
        logic                 vld;
        logic                 claim;
        action_t              action;
        logic [127:0]         addr;
        logic [LEN_W-1:0]     len;
        logic [VALUE_W-1:0]   value;
        logic                 found;
        logic                 free_seen;
        logic                 hit;
        logic [LEN_W-1:0]     best_len;
        logic [VALUE_W-1:0]   best_val;
    } tok_t;

    // Keep the first len bits (from bit 127 down); len of 128 or more keeps all
    function automatic logic [127:0] pfx_mask(input logic [LEN_W-1:0] len);
        logic [127:0] m;
        m = ~({128{1'b1}} >> len);
        return m;
    endfunction

endpackage

@@ src/ipv6_lpm_cell.sv @@
// One prefix slot of the chain: holds prefix, length and value, and updates the
// passing token. Depends on ipv6_lpm_pkg.
module ipv6_lpm_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  ipv6_lpm_pkg::tok_t tok_in,
    output ipv6_lpm_pkg::tok_t tok_out
);

    logic                                   valid_reg, valid_next;
    logic [127:0]                           pfx_reg;
    logic [ipv6_lpm_pkg::LEN_W-1:0]         len_reg;
    logic [ipv6_lpm_pkg::VALUE_W-1:0]       value_reg, value_next;
    logic                                   wr_slot;
    ipv6_lpm_pkg::tok_t                     tok_reg, tok_next;
    logic                                   vld_reg;
    logic                                   exact;
    logic                                   covers;

    assign exact  = valid_reg && (len_reg == tok_in.len) && (pfx_reg == tok_in.addr);
    assign covers = valid_reg &&
                    ((tok_in.addr & ipv6_lpm_pkg::pfx_mask(len_reg)) == pfx_reg);

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        value_next = value_reg;
        wr_slot    = 1'b0;
        if (tok_in.vld)
        begin
            if (tok_in.claim)
            begin
                // second pass: the first free slot takes the new prefix
                if (!valid_reg)
                begin
                    wr_slot        = 1'b1;
                    valid_next     = 1'b1;
                    value_next     = tok_in.value;
                    tok_next.claim = 1'b0;
                    tok_next.found = 1'b1;
                end
            end
            else
            begin
                case (tok_in.action)
                    ipv6_lpm_pkg::ACT_INSERT:
                    begin
                        if (exact)
                        begin
                            value_next     = tok_in.value;
                            tok_next.found = 1'b1;
                        end
                        if (!valid_reg)
                            tok_next.free_seen = 1'b1;
                    end
                    ipv6_lpm_pkg::ACT_REMOVE:
                    begin
                        if (exact)
                        begin
                            valid_next     = 1'b0;
                            tok_next.found = 1'b1;
                        end
                    end
                    ipv6_lpm_pkg::ACT_LOOKUP:
                    begin
                        if (covers && (!tok_in.hit || (len_reg > tok_in.best_len)))
                        begin
                            tok_next.hit      = 1'b1;
                            tok_next.best_len = len_reg;
                            tok_next.best_val = value_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            vld_reg   <= tok_next.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        tok_reg   <= tok_next;
        if (wr_slot)
        begin
            pfx_reg <= tok_in.addr;
            len_reg <= tok_in.len;
        end
    end

    // only the valid flag of the token carries a reset
    always_comb
    begin
        tok_out     = tok_reg;
        tok_out.vld = vld_reg;
    end

endmodule

@@ src/ipv6_lpm_ctrl.sv @@
// Sequencer for the prefix table: accepts a transaction, sends tokens down the
// cell chain, keeps the prefix count and holds the result. Depends on ipv6_lpm_pkg.
module ipv6_lpm_ctrl
#(
    parameter int unsigned TABLE_ENTRIES = ipv6_lpm_pkg::DEF_TABLE_ENTRIES
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [ipv6_lpm_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [ipv6_lpm_pkg::OUT_DATA_W-1:0]     m_tdata,
    output ipv6_lpm_pkg::tok_t                      inject,
    input  ipv6_lpm_pkg::tok_t                      chain_out
);

    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

    ipv6_lpm_pkg::state_t                       state_reg, state_next;
    ipv6_lpm_pkg::tok_t                         tok_reg, tok_next;
    logic                                       tok_vld_reg;
    logic [CW-1:0]                              count_reg, count_next;
    ipv6_lpm_pkg::status_t                      st_reg, st_next;
    logic                                       hit_reg, hit_next;
    logic [ipv6_lpm_pkg::VALUE_W-1:0]           fv_reg, fv_next;
    logic                                       mv_reg, mv_next;
    logic [ipv6_lpm_pkg::OUT_DATA_W-1:0]        md_reg, md_next;
    logic [CW+8:0]                              count_ext;

    ipv6_lpm_pkg::action_t                      in_act;
    logic [127:0]                               in_addr;
    logic [ipv6_lpm_pkg::LEN_W-1:0]             in_len;
    logic                                       in_rw;
    logic                                       bad_len;
    logic                                       accept;
    logic                                       out_free;

    assign in_act   = ipv6_lpm_pkg::action_t'(s_tdata[1:0]);
    assign in_addr  = {s_tdata[65:2], s_tdata[129:66]};
    assign in_len   = s_tdata[137:130];
    assign in_rw    = (in_act == ipv6_lpm_pkg::ACT_INSERT) ||
                      (in_act == ipv6_lpm_pkg::ACT_REMOVE);
    assign bad_len  = in_len > 8'd128;
    assign s_tready = (state_reg == ipv6_lpm_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign count_ext = {9'd0, count_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ipv6_lpm_pkg::S_IDLE:
                if (accept)
                    state_next = (in_rw && bad_len) || (in_act == ipv6_lpm_pkg::ACT_NONE) ?
                                 ipv6_lpm_pkg::S_DONE : ipv6_lpm_pkg::S_PASS1;
            ipv6_lpm_pkg::S_PASS1:
                if (chain_out.vld)
                    state_next = (chain_out.action == ipv6_lpm_pkg::ACT_INSERT) &&
                                 !chain_out.found && chain_out.free_seen ?
                                 ipv6_lpm_pkg::S_PASS2 : ipv6_lpm_pkg::S_DONE;
            ipv6_lpm_pkg::S_PASS2:
                if (chain_out.vld)
                    state_next = ipv6_lpm_pkg::S_DONE;
            ipv6_lpm_pkg::S_DONE:
                if (out_free)
                    state_next = ipv6_lpm_pkg::S_IDLE;
            default:
                state_next = ipv6_lpm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        tok_next     = tok_reg;
        tok_next.vld = 1'b0;
        count_next   = count_reg;
        st_next      = st_reg;
        hit_next     = hit_reg;
        fv_next      = fv_reg;
        mv_next      = mv_reg && !m_tready;
        md_next      = md_reg;
        unique case (state_reg)
            ipv6_lpm_pkg::S_IDLE:
            begin
                st_next  = bad_len && in_rw ? ipv6_lpm_pkg::ST_BAD_LEN : ipv6_lpm_pkg::ST_OK;
                hit_next = 1'b0;
                fv_next  = '0;
                if (accept)
                begin
                    tok_next.vld       = !(in_rw && bad_len) &&
                                         (in_act != ipv6_lpm_pkg::ACT_NONE);
                    tok_next.claim     = 1'b0;
                    tok_next.action    = in_act;
                    tok_next.addr      = in_rw ? in_addr & ipv6_lpm_pkg::pfx_mask(in_len)
                                               : in_addr;
                    tok_next.len       = in_len;
                    tok_next.value     = s_tdata[169:138];
                    tok_next.found     = 1'b0;
                    tok_next.free_seen = 1'b0;
                    tok_next.hit       = 1'b0;
                    tok_next.best_len  = '0;
                    tok_next.best_val  = '0;
                end
            end
            ipv6_lpm_pkg::S_PASS1:
            begin
                if (chain_out.vld)
                begin
                    case (chain_out.action)
                        ipv6_lpm_pkg::ACT_INSERT:
                        begin
                            if (!chain_out.found && chain_out.free_seen)
                            begin
                                tok_next       = chain_out;
                                tok_next.claim = 1'b1;
                            end
                            else if (!chain_out.found)
                                st_next = ipv6_lpm_pkg::ST_NO_SPACE;
                        end
                        ipv6_lpm_pkg::ACT_REMOVE:
                        begin
                            if (chain_out.found)
                                count_next = count_reg - CW'(1);
                            else
                                st_next = ipv6_lpm_pkg::ST_NOT_FOUND;
                        end
                        default:
                        begin
                            hit_next = chain_out.hit;
                            fv_next  = chain_out.hit ? chain_out.best_val : '0;
                        end
                    endcase
                end
            end
            ipv6_lpm_pkg::S_PASS2:
            begin
                if (chain_out.vld)
                    count_next = count_reg + CW'(1);
            end
            ipv6_lpm_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    mv_next = 1'b1;
                    md_next = {4'd0, count_ext[8:0], fv_reg, hit_reg, st_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ipv6_lpm_pkg::S_IDLE;
            count_reg   <= '0;
            mv_reg      <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            mv_reg      <= mv_next;
            tok_vld_reg <= tok_next.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        st_reg  <= st_next;
        hit_reg <= hit_next;
        fv_reg  <= fv_next;
        md_reg  <= md_next;
    end

    // only the valid flag of the injected token carries a reset
    always_comb
    begin
        inject     = tok_reg;
        inject.vld = tok_vld_reg;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_ENTRIES))
        else $error("prefix count above table size");
    a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.vld |-> (state_reg == ipv6_lpm_pkg::S_PASS1 ||
                           state_reg == ipv6_lpm_pkg::S_PASS2))
        else $error("token left chain while idle");
    a_pass2_claim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ipv6_lpm_pkg::S_PASS2 && chain_out.vld) |-> !chain_out.claim)
        else $error("claim token found no free slot");
`endif

endmodule

@@ src/ipv6_longest_prefix_match_table.sv @@
// IPv6 longest-prefix-match table, top level: sequencer plus a chain of slot cells.
// Depends on ipv6_lpm_pkg, ipv6_lpm_cell and ipv6_lpm_ctrl.
//
// Usage: one request transaction on the s_ channel (insert, remove or lookup)
// gives exactly one result transaction on the m_ channel.
// Each request token walks a chain of TABLE_ENTRIES cells, one cell per cycle,
// once for lookup, remove and an overwrite, and twice for an insert of a new
// prefix (second pass that claims the lowest free slot). Invalid insert or
// remove lengths and the unused action code skip the chain and answer directly.
// One request is in flight at a time; the chain length sets the throughput.
// The result sits in an output register: a new request is taken while the
// previous result still waits; a stalled receiver holds m_tvalid and m_tdata
// and the finished request waits until the register frees.
// Reset clears all slot valid bits and the prefix count; no clearing pass.
module ipv6_longest_prefix_match_table
#(
    parameter int unsigned TABLE_ENTRIES = ipv6_lpm_pkg::DEF_TABLE_ENTRIES
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // action[1:0], addr_hi[65:2], addr_lo[129:66], pfx_len[137:130],
    // entry_value[169:138], zero fill
    input  logic [ipv6_lpm_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[1:0], hit[2], found_value[34:3], prefix_count[43:35], zero fill
    output logic [ipv6_lpm_pkg::OUT_DATA_W-1:0] m_tdata
);

    // link[i] feeds cell i; link[TABLE_ENTRIES] returns to the sequencer
    ipv6_lpm_pkg::tok_t link [0:TABLE_ENTRIES];

    ipv6_lpm_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .inject    (link[0]),
        .chain_out (link[TABLE_ENTRIES])
    );

    // Advance the token one slot per cycle
    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        ipv6_lpm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (link[g]),
            .tok_out (link[g+1])
        );
    end

endmodule

@@ verif/ipv6_lpm_checker.sv @@
// Checker for the IPv6 longest-prefix-match table: watches both stream channels,
// keeps its own copy of the prefix store and compares each result transaction.
// Depends on ipv6_lpm_pkg.
`timescale 1ns / 100ps

module ipv6_lpm_checker
#(
    parameter int unsigned ENTRIES = ipv6_lpm_pkg::DEF_TABLE_ENTRIES
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [ipv6_lpm_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [ipv6_lpm_pkg::OUT_DATA_W-1:0] m_tdata,
    output int                                  errors,
    output int                                  pending
);

    // status in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [ipv6_lpm_pkg::COUNT_W-1:0]  count;
        logic [ipv6_lpm_pkg::VALUE_W-1:0]  value;
        logic                              hit;
        ipv6_lpm_pkg::status_t             status;
    } answer_t;

    bit                                 live  [ENTRIES];
    logic [127:0]                       pfx   [ENTRIES];
    logic [ipv6_lpm_pkg::LEN_W-1:0]     plen  [ENTRIES];
    logic [ipv6_lpm_pkg::VALUE_W-1:0]   pval  [ENTRIES];
    int unsigned                        count_now;
    answer_t                            answers_due [$];

    assign pending = answers_due.size();

    function automatic logic [127:0] keep_bits(input int unsigned n);
        logic [127:0] m;
        m = '0;
        for (int b = 0; b < 128; b++)
            if (b >= 128 - int'(n)) m[b] = 1'b1;
        return m;
    endfunction

    // Apply one request to the shadow store and return what the table must answer
    function automatic answer_t apply_request(input logic [ipv6_lpm_pkg::IN_DATA_W-1:0] d);
        ipv6_lpm_pkg::action_t          act;
        logic [127:0]                   addr;
        logic [127:0]                   key;
        logic [ipv6_lpm_pkg::LEN_W-1:0] len;
        int                             slot;
        int                             spare;
        int unsigned                    best;
        answer_t                        a;
        act  = ipv6_lpm_pkg::action_t'(d[1:0]);
        addr = {d[65:2], d[129:66]};
        len  = d[137:130];
        a    = '{status: ipv6_lpm_pkg::ST_OK, hit: 1'b0, value: '0, count: '0};
        if (act == ipv6_lpm_pkg::ACT_INSERT || act == ipv6_lpm_pkg::ACT_REMOVE)
        begin
            if (len > 128)
            begin
                a.status = ipv6_lpm_pkg::ST_BAD_LEN;
            end
            else
            begin
                key   = addr & keep_bits(len);
                slot  = -1;
                spare = -1;
                for (int i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (live[i] && plen[i] == len && pfx[i] == key) slot = i;
                    if (!live[i]) spare = i;
                end
                if (act == ipv6_lpm_pkg::ACT_INSERT)
                begin
                    if (slot >= 0) pval[slot] = d[169:138];
                    else if (spare < 0) a.status = ipv6_lpm_pkg::ST_NO_SPACE;
                    else
                    begin
                        live[spare] = 1;
                        pfx[spare]  = key;
                        plen[spare] = len;
                        pval[spare] = d[169:138];
                        count_now++;
                    end
                end
                else if (slot < 0) a.status = ipv6_lpm_pkg::ST_NOT_FOUND;
                else
                begin
                    live[slot] = 0;
                    if (count_now > 0) count_now--;
                end
            end
        end
        else if (act == ipv6_lpm_pkg::ACT_LOOKUP)
        begin
            best = 0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (live[i] && (addr & keep_bits(plen[i])) == pfx[i]
                    && (!a.hit || plen[i] > best))
                begin
                    a.hit   = 1;
                    best    = plen[i];
                    a.value = pval[i];
                end
            end
        end
        a.count = count_now[ipv6_lpm_pkg::COUNT_W-1:0];
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        answer_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++) live[i] = 0;
            count_now = 0;
            answers_due.delete();
            errors = 0;
        end
        else
        begin
            // take the result before the request: a request never answers in the same edge
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[43:0];
                if (answers_due.size() == 0)
                begin
                    $error("result transaction with nothing expected: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.hit !== want.hit)
                    begin
                        $error("hit expected %0d actual %0d", want.hit, got.hit);
                        errors++;
                    end
                    if (got.value !== want.value)
                    begin
                        $error("found_value expected %h actual %h", want.value, got.value);
                        errors++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("prefix_count expected %0d actual %0d", want.count, got.count);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) answers_due.push_back(apply_request(s_tdata));
        end
    end

endmodule

@@ verif/tb_ipv6_longest_prefix_match_table.sv @@
// Testbench top for the IPv6 longest-prefix-match table: drives request
// transactions with random gaps and back-pressure, gives the verdict.
// Depends on ipv6_lpm_pkg, ipv6_lpm_checker and the table RTL.
`timescale 1ns / 100ps

module tb_ipv6_longest_prefix_match_table;

    // Slow path: new-prefix insert walks the chain twice
    localparam int unsigned SLOW_LAT    = 2 * ipv6_lpm_pkg::DEF_TABLE_ENTRIES + 4;
    localparam int unsigned FILL_REQS   = ipv6_lpm_pkg::DEF_TABLE_ENTRIES + 2;
    localparam int unsigned RANDOM_REQS = 450;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    logic                                clk;
    logic                                rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [ipv6_lpm_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [ipv6_lpm_pkg::OUT_DATA_W-1:0] m_tdata;
    int                                  errors;
    int                                  pending;
    int                                  send_idle_pct;
    int                                  recv_idle_pct;
    bit                                  hold_go;
    logic                                hold_active;
    longint unsigned                     cycles = 0;

    // Small pool of prefixes so inserts, overwrites, removes and hits all recur
    logic [127:0]          route_pool [16];
    logic [7:0]            route_len  [16];
    // Prefixes used to fill the store, kept so they can be drained again
    logic [127:0]          fill_addr  [FILL_REQS];
    logic [7:0]            fill_len   [FILL_REQS];

    ipv6_longest_prefix_match_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ipv6_lpm_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [127:0] rand_addr();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Offer one request transaction and hold it until accepted; drop valid while idling
    task automatic send_request(input ipv6_lpm_pkg::action_t act, input logic [127:0] addr,
                                input logic [7:0] len, input logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {6'b0, val, len, addr[63:0], addr[127:64], act};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Pick a mostly well-formed request around the pool, with some noise
    task automatic send_random();
        int unsigned  pick;
        int unsigned  k;
        logic [127:0] addr;
        logic [7:0]   len;
        pick = $urandom_range(99);
        k    = $urandom_range(15);
        addr = route_pool[k] | (rand_addr() & ~(~128'b0 << (128 - route_len[k])));
        len  = route_len[k];
        if (pick < 35)
            send_request(ipv6_lpm_pkg::ACT_INSERT, addr, len, $urandom);
        else if (pick < 50)
            send_request(ipv6_lpm_pkg::ACT_REMOVE, addr, len, $urandom);
        else if (pick < 85)
            send_request(ipv6_lpm_pkg::ACT_LOOKUP, addr, 8'($urandom), $urandom);
        else if (pick < 90)
            send_request(ipv6_lpm_pkg::ACT_LOOKUP, rand_addr(), 8'($urandom), $urandom);
        else if (pick < 94)
            send_request(ipv6_lpm_pkg::action_t'($urandom_range(1)), rand_addr(),
                         8'($urandom_range(255, 129)), $urandom);
        else if (pick < 97)
            send_request(ipv6_lpm_pkg::ACT_NONE, rand_addr(), 8'($urandom), $urandom);
        else
            send_request(ipv6_lpm_pkg::ACT_INSERT, rand_addr(), 8'($urandom_range(128)),
                         $urandom);
    endtask

    // Long receiver hold-off, counted here while requests keep coming
    initial
    begin
        hold_active = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (4 * SLOW_LAT) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Receiver: random stalls, held off completely during the hold-off stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_active)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog and cycle count
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL ipv6_longest_prefix_match_table");
            $finish;
        end
    end

    initial
    begin
        logic [127:0] a;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go       = 0;
        for (int i = 0; i < 16; i++)
        begin
            route_len[i]  = (i == 0) ? 8'd0 : (i == 1) ? 8'd128 : (i == 2) ? 8'd64
                          : 8'($urandom_range(1, 128));
            route_pool[i] = rand_addr() & ~(~128'b0 >> route_len[i]);
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty lookup, extremes of length, overwrite, remove, bad codes
        a = rand_addr();
        send_request(ipv6_lpm_pkg::ACT_LOOKUP, '1, 8'hff, '1);
        send_request(ipv6_lpm_pkg::ACT_REMOVE, a, 8'd40, 32'd0);
        send_request(ipv6_lpm_pkg::ACT_INSERT, '0, 8'd0, 32'hffff_ffff);
        send_request(ipv6_lpm_pkg::ACT_LOOKUP, '1, 8'd0, 32'd0);
        send_request(ipv6_lpm_pkg::ACT_INSERT, '1, 8'd128, 32'h1234_5678);
        send_request(ipv6_lpm_pkg::ACT_INSERT, a, 8'd64, 32'h0000_0001);
        send_request(ipv6_lpm_pkg::ACT_INSERT, a, 8'd1, 32'h0000_0002);
        send_request(ipv6_lpm_pkg::ACT_INSERT, a, 8'd127, 32'h0000_0003);
        send_request(ipv6_lpm_pkg::ACT_INSERT, a, 8'd64, 32'hdead_beef);
        send_request(ipv6_lpm_pkg::ACT_LOOKUP, '1, 8'd0, 32'd0);
        send_request(ipv6_lpm_pkg::ACT_LOOKUP, a, 8'd0, 32'd0);
        send_request(ipv6_lpm_pkg::ACT_LOOKUP, a ^ 128'd1, 8'd0, 32'd0);
        send_request(ipv6_lpm_pkg::ACT_LOOKUP, ~a, 8'd0, 32'd0);
        send_request(ipv6_lpm_pkg::ACT_INSERT, a, 8'd129, 32'd5);
        send_request(ipv6_lpm_pkg::ACT_REMOVE, a, 8'd255, 32'd5);
        send_request(ipv6_lpm_pkg::ACT_NONE, '1, 8'hff, '1);
        send_request(ipv6_lpm_pkg::ACT_REMOVE, a, 8'd127, 32'd0);
        send_request(ipv6_lpm_pkg::ACT_REMOVE, a, 8'd127, 32'd0);
        send_request(ipv6_lpm_pkg::ACT_REMOVE, '0, 8'd0, 32'd0);
        send_request(ipv6_lpm_pkg::ACT_LOOKUP, ~a, 8'd0, 32'd0);

        // Fill the store to capacity, hit no space, then drain it again
        for (int i = 0; i < FILL_REQS; i++)
        begin
            fill_addr[i] = rand_addr();
            fill_len[i]  = 8'($urandom_range(96, 128));
            send_request(ipv6_lpm_pkg::ACT_INSERT, fill_addr[i], fill_len[i], $urandom);
        end
        send_request(ipv6_lpm_pkg::ACT_LOOKUP, a, 8'd0, 32'd0);
        send_request(ipv6_lpm_pkg::ACT_INSERT, a, 8'd64, 32'h5555_aaaa);
        for (int i = 0; i < ipv6_lpm_pkg::DEF_TABLE_ENTRIES; i++)
            send_request(ipv6_lpm_pkg::ACT_REMOVE, fill_addr[i], fill_len[i], 32'd0);
        send_request(ipv6_lpm_pkg::ACT_REMOVE, a, 8'd64, 32'd0);
        send_request(ipv6_lpm_pkg::ACT_REMOVE, '1, 8'd128, 32'd0);

        // Random phases: slow receiver, then slow sender, then free running with the receiver hold-off
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 84 : 0;
            recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 15 : 0;
            if (phase == 2) hold_go = 1;
            for (int n = 0; n < RANDOM_REQS / 3; n++) send_random();
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (SLOW_LAT) @(posedge clk);
        if (errors == 0)
            $display("PASS ipv6_longest_prefix_match_table");
        else
            $display("FAIL ipv6_longest_prefix_match_table");
        $finish;
    end

endmodule
